@@ rtl/core/pdag_pkg.sv @@
// shared constants for the poisson disc acceptance grid
`default_nettype none
package pdag_pkg;
    localparam int GRID_COLS_DEF  = 64;
    localparam int GRID_ROWS_DEF  = 64;
    localparam int MAX_POINTS_DEF = 4096;
    localparam int MAX_SPAN_DEF   = 10;

    localparam int COORD_W = 24;
    localparam int RAD_W   = 16;
    localparam int ST_W    = 3;
    localparam int IDX_W   = 3;
    localparam int ENT_W   = 64;

    localparam logic [ST_W-1:0] ST_ACCEPTED  = 3'd0;
    localparam logic [ST_W-1:0] ST_OUTSIDE   = 3'd1;
    localparam logic [ST_W-1:0] ST_TOO_CLOSE = 3'd2;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd3;
    localparam logic [ST_W-1:0] ST_CLEARED   = 3'd4;

    localparam logic [IDX_W-1:0] REG_WIDTH  = 3'd0;
    localparam logic [IDX_W-1:0] REG_HEIGHT = 3'd1;
    localparam logic [IDX_W-1:0] REG_SCALE  = 3'd2;
    localparam logic [IDX_W-1:0] REG_COLS   = 3'd3;
    localparam logic [IDX_W-1:0] REG_ROWS   = 3'd4;
    localparam logic [IDX_W-1:0] REG_SPAN   = 3'd5;

    localparam logic            CMD_CLEAR = 1'b0;
    localparam logic            CMD_OFFER = 1'b1;
endpackage
`default_nettype wire

@@ rtl/core/pdag_if.sv @@
// handshake channel interfaces: candidate input, result output, register writes
`default_nettype none
interface pdag_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [23:0] pos_x;
    logic [23:0] pos_y;
    logic [15:0] cand_radius;
    modport source (output valid, command, pos_x, pos_y, cand_radius, input ready);
    modport sink   (input valid, command, pos_x, pos_y, cand_radius, output ready);
endinterface

interface pdag_out_if #(parameter int PNW = 13);
    logic           valid;
    logic           ready;
    logic           accepted;
    logic [PNW-1:0] point_number;
    logic [2:0]     status;
    modport source (output valid, accepted, point_number, status, input ready);
    modport sink   (input valid, accepted, point_number, status, output ready);
endinterface

interface pdag_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [23:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/pdag_ram.sv @@
// generic single write port ram with registered read
`default_nettype none
module pdag_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_we,
    input  wire logic [(D > 1 ? $clog2(D) : 1)-1:0] i_waddr,
    input  wire logic [W-1:0]                  i_wdata,
    input  wire logic [(D > 1 ? $clog2(D) : 1)-1:0] i_raddr,
    output logic      [W-1:0]                  o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ rtl/core/pdag_mul.sv @@
// shared 24x24 multiplier with registered product
`default_nettype none
module pdag_mul (
    input  wire logic        i_clk,
    input  wire logic [23:0] i_a,
    input  wire logic [23:0] i_b,
    output logic      [47:0] o_p
);
    always_ff @(posedge i_clk) begin
        o_p <= 48'(i_a) * 48'(i_b);
    end
endmodule
`default_nettype wire

@@ rtl/core/poisson_disc_acceptance_grid_core.sv @@
// accept-or-reject engine for variable-radius poisson disc sampling
// usage:
//  - i_in carries a command (clear or offer) with a Q16.8 position and Q8.8 radius;
//    o_out returns one result per transaction (accepted, point number, status); i_cfg
//    is always ready and writes the six registers; the user must do so only while idle, unchecked by the block
//  - one shared 24x24 multiplier under a sequencer does the cell index, the
//    radius square and every distance test; an offer computes the cell index
//    and radius square, reads each window cell, tests each occupied one until
//    one is too close, writes back a point it accepts and returns the result;
//    default span 2 gives a full 5x5 window, smaller where clipped at the grid edge
//  - a window cell is fetched from the cell map ram, then the stored point
//    from the point store ram, one read port each
//  - a clear command and reset both run a pass over all GRID_ROWS*GRID_COLS
//    cell map entries, one a cycle (4096 by default); no candidate is taken
//    meanwhile, and a clear returns its result after the pass
//  - i_in.ready is high only when the sequencer is idle; a finished result
//    waits in the output register when o_out.ready is low, and the engine
//    stalls only if a second result is ready before the first is taken
`default_nettype none
module poisson_disc_acceptance_grid_core #(
    parameter int GRID_COLS  = pdag_pkg::GRID_COLS_DEF,
    parameter int GRID_ROWS  = pdag_pkg::GRID_ROWS_DEF,
    parameter int MAX_POINTS = pdag_pkg::MAX_POINTS_DEF,
    parameter int MAX_SPAN   = pdag_pkg::MAX_SPAN_DEF
) (
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    pdag_in_if.sink     i_in,
    pdag_out_if.source  o_out,
    pdag_cfg_if.sink    i_cfg
);
    import pdag_pkg::*;

    localparam int CCW   = $clog2(GRID_COLS + 1);
    localparam int RCW   = $clog2(GRID_ROWS + 1);
    localparam int CIW   = GRID_COLS > 1 ? $clog2(GRID_COLS) : 1;
    localparam int RIW   = GRID_ROWS > 1 ? $clog2(GRID_ROWS) : 1;
    localparam int MAP_D = GRID_COLS * GRID_ROWS;
    localparam int MAW   = MAP_D > 1 ? $clog2(MAP_D) : 1;
    localparam int PNW   = $clog2(MAX_POINTS + 1);
    localparam int SAW   = MAX_POINTS > 1 ? $clog2(MAX_POINTS) : 1;
    localparam int XW    = CCW + 5;
    localparam int YW    = RCW + 5;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CHK  = 4'd1;
    localparam logic [3:0] S_CX   = 4'd2;
    localparam logic [3:0] S_CY   = 4'd3;
    localparam logic [3:0] S_RR   = 4'd4;
    localparam logic [3:0] S_MAP  = 4'd5;
    localparam logic [3:0] S_MAPD = 4'd6;
    localparam logic [3:0] S_PT   = 4'd7;
    localparam logic [3:0] S_DX   = 4'd8;
    localparam logic [3:0] S_DY   = 4'd9;
    localparam logic [3:0] S_PR   = 4'd10;
    localparam logic [3:0] S_FIN  = 4'd11;
    localparam logic [3:0] S_CLR  = 4'd12;
    localparam logic [3:0] S_RES  = 4'd13;

    // configuration
    logic [23:0] r_width, r_height, r_scale;
    logic [6:0]  r_cols, r_rows;
    logic [3:0]  r_span;

    // sequencer state
    logic [3:0]     r_state, n_state;
    logic [23:0]    r_x, r_y;
    logic [15:0]    r_r;
    logic           r_outside;
    logic [23:0]    r_cx, r_cy;
    logic [31:0]    r_rr;
    logic [48:0]    r_acc;
    logic [CIW-1:0] r_i, r_x1;
    logic [RIW-1:0] r_j, r_y0, r_y1;
    logic [ENT_W-1:0] r_ent;
    logic [PNW-1:0] r_cnt;
    logic [MAW-1:0] r_clr;
    logic           r_clr_cmd;
    logic           r_res_acc;
    logic [PNW-1:0] r_res_num;
    logic [ST_W-1:0] r_res_st;
    logic           r_out_vld;
    logic           r_out_acc;
    logic [PNW-1:0] r_out_num;
    logic [ST_W-1:0] r_out_st;

    // effective sizes
    logic [CCW-1:0] cols_eff;
    logic [RCW-1:0] rows_eff;
    logic [3:0]     span_eff;

    always_comb begin
        if (r_cols == 7'd0) begin
            cols_eff = CCW'(1);
        end else if (32'(r_cols) > GRID_COLS) begin
            cols_eff = CCW'(GRID_COLS);
        end else begin
            cols_eff = CCW'(r_cols);
        end
        if (r_rows == 7'd0) begin
            rows_eff = RCW'(1);
        end else if (32'(r_rows) > GRID_ROWS) begin
            rows_eff = RCW'(GRID_ROWS);
        end else begin
            rows_eff = RCW'(r_rows);
        end
        span_eff = (32'(r_span) > MAX_SPAN) ? 4'(MAX_SPAN) : r_span;
    end

    // window bounds from the candidate cell
    logic [XW-1:0] cxw, xsum;
    logic [YW-1:0] cyw, ysum;
    logic [CIW-1:0] x0_c, x1_c;
    logic [RIW-1:0] y0_c, y1_c;
    logic cell_out;

    always_comb begin
        cxw  = XW'(r_cx[CIW-1:0]);
        cyw  = YW'(r_cy[RIW-1:0]);
        xsum = cxw + XW'(span_eff);
        ysum = cyw + YW'(span_eff);
        x0_c = (cxw > XW'(span_eff)) ? CIW'(cxw - XW'(span_eff)) : '0;
        y0_c = (cyw > YW'(span_eff)) ? RIW'(cyw - YW'(span_eff)) : '0;
        x1_c = (xsum < XW'(cols_eff)) ? CIW'(xsum) : CIW'(cols_eff - CCW'(1));
        y1_c = (ysum < YW'(rows_eff)) ? RIW'(ysum) : RIW'(rows_eff - RCW'(1));
        cell_out = (r_cx >= 24'(cols_eff)) || (r_cy >= 24'(rows_eff));
    end

    // shared multiplier
    logic [23:0] mul_a, mul_b;
    logic [47:0] prod;
    logic [ENT_W-1:0] st_rdata;
    logic [23:0] dx_c, dy_c;

    always_comb begin
        dx_c = (r_x > st_rdata[23:0]) ? r_x - st_rdata[23:0] : st_rdata[23:0] - r_x;
        dy_c = (r_y > r_ent[47:24]) ? r_y - r_ent[47:24] : r_ent[47:24] - r_y;
        case (r_state)
            S_CHK:   begin mul_a = r_x;          mul_b = r_scale;      end
            S_CX:    begin mul_a = r_y;          mul_b = r_scale;      end
            S_CY:    begin mul_a = 24'(r_r);     mul_b = 24'(r_r);     end
            S_PT:    begin mul_a = dx_c;         mul_b = dx_c;         end
            S_DX:    begin mul_a = dy_c;         mul_b = dy_c;         end
            S_DY:    begin mul_a = 24'(r_ent[63:48]); mul_b = 24'(r_ent[63:48]); end
            default: begin mul_a = '0;           mul_b = '0;           end
        endcase
    end

    pdag_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    // memories
    logic [PNW-1:0] map_rdata, map_wdata;
    logic [MAW-1:0] map_waddr, map_raddr, cand_addr;
    logic           map_we, st_we;
    logic           full, num_ok, too_close;

    always_comb begin
        cand_addr = MAW'(r_cy[RIW-1:0]) * MAW'(GRID_COLS) + MAW'(r_cx[CIW-1:0]);
        map_raddr = MAW'(r_j) * MAW'(GRID_COLS) + MAW'(r_i);
        full      = (32'(r_cnt) >= MAX_POINTS);
        map_we    = (r_state == S_CLR) || (r_state == S_FIN && !full);
        map_waddr = (r_state == S_CLR) ? r_clr : cand_addr;
        map_wdata = (r_state == S_CLR) ? '0 : PNW'(r_cnt + PNW'(1));
        st_we     = (r_state == S_FIN) && !full;
        num_ok    = (map_rdata != '0) && (map_rdata <= r_cnt);
        too_close = (r_acc < 49'(r_rr)) || (r_acc < 49'(prod));
    end

    pdag_ram #(.W(PNW), .D(MAP_D)) u_cell_map (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    pdag_ram #(.W(ENT_W), .D(MAX_POINTS)) u_point_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (SAW'(r_cnt)),
        .i_wdata ({r_r, r_y, r_x}),
        .i_raddr (SAW'(map_rdata - PNW'(1))),
        .o_rdata (st_rdata)
    );

    // window walk
    logic last_j, last_i;
    assign last_j = (r_j == r_y1);
    assign last_i = (r_i == r_x1);

    logic in_acc, cfg_acc, out_take;
    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_acc   = i_in.valid && i_in.ready;
    assign cfg_acc  = i_cfg.valid;
    assign out_take = r_out_vld && o_out.ready;

    assign o_out.valid        = r_out_vld;
    assign o_out.accepted     = r_out_acc;
    assign o_out.point_number = r_out_num;
    assign o_out.status       = r_out_st;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (in_acc) begin
                n_state = (i_in.command == CMD_CLEAR) ? S_CLR : S_CHK;
            end
            S_CHK:  n_state = r_outside ? S_RES : S_CX;
            S_CX:   n_state = S_CY;
            S_CY:   n_state = S_RR;
            S_RR:   n_state = cell_out ? S_RES : S_MAP;
            S_MAP:  n_state = S_MAPD;
            S_MAPD: begin
                if (num_ok) begin
                    n_state = S_PT;
                end else begin
                    n_state = (last_i && last_j) ? S_FIN : S_MAP;
                end
            end
            S_PT:   n_state = S_DX;
            S_DX:   n_state = S_DY;
            S_DY:   n_state = S_PR;
            S_PR: begin
                if (too_close) begin
                    n_state = S_RES;
                end else begin
                    n_state = (last_i && last_j) ? S_FIN : S_MAP;
                end
            end
            S_FIN:  n_state = S_RES;
            S_CLR: if (r_clr == MAW'(MAP_D - 1)) begin
                n_state = r_clr_cmd ? S_RES : S_IDLE;
            end
            S_RES: if (!r_out_vld || o_out.ready) begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr     <= '0;
            r_clr_cmd <= 1'b0;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
            r_width   <= 24'd16384;
            r_height  <= 24'd16384;
            r_scale   <= 24'd65536;
            r_cols    <= 7'd64;
            r_rows    <= 7'd64;
            r_span    <= 4'd2;
        end else begin
            r_state <= n_state;
            if (cfg_acc) begin
                case (i_cfg.index)
                    REG_WIDTH:  r_width  <= i_cfg.data;
                    REG_HEIGHT: r_height <= i_cfg.data;
                    REG_SCALE:  r_scale  <= i_cfg.data;
                    REG_COLS:   r_cols   <= i_cfg.data[6:0];
                    REG_ROWS:   r_rows   <= i_cfg.data[6:0];
                    REG_SPAN:   r_span   <= i_cfg.data[3:0];
                    default: ;
                endcase
            end
            // a new result may replace the one taken in the same cycle
            if (r_state == S_RES && (!r_out_vld || o_out.ready)) begin
                r_out_vld <= 1'b1;
            end else if (out_take) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: if (in_acc && i_in.command == CMD_CLEAR) begin
                    r_cnt     <= '0;
                    r_clr     <= '0;
                    r_clr_cmd <= 1'b1;
                end
                S_CLR: r_clr <= r_clr + MAW'(1);
                S_FIN: if (!full) begin
                    r_cnt <= r_cnt + PNW'(1);
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: if (in_acc) begin
                r_x <= i_in.pos_x;
                r_y <= i_in.pos_y;
                r_r <= i_in.cand_radius;
                r_outside <= (i_in.pos_x == '0) || (i_in.pos_x >= r_width) ||
                             (i_in.pos_y == '0) || (i_in.pos_y >= r_height);
                r_res_acc <= 1'b0;
                r_res_num <= '0;
                r_res_st  <= ST_CLEARED;
            end
            S_CHK: if (r_outside) begin
                r_res_st <= ST_OUTSIDE;
            end
            S_CX: r_cx <= prod[47:24];
            S_CY: r_cy <= prod[47:24];
            S_RR: begin
                r_rr <= prod[31:0];
                r_i  <= x0_c;
                r_x1 <= x1_c;
                r_j  <= y0_c;
                r_y0 <= y0_c;
                r_y1 <= y1_c;
                if (cell_out) begin
                    r_res_st <= ST_OUTSIDE;
                end
            end
            S_MAPD: if (!num_ok) begin
                if (last_j) begin
                    r_j <= r_y0;
                    r_i <= r_i + CIW'(1);
                end else begin
                    r_j <= r_j + RIW'(1);
                end
            end
            S_PT: r_ent <= st_rdata;
            S_DX: r_acc <= 49'(prod);
            S_DY: r_acc <= r_acc + 49'(prod);
            S_PR: begin
                if (too_close) begin
                    r_res_st <= ST_TOO_CLOSE;
                end else if (last_j) begin
                    r_j <= r_y0;
                    r_i <= r_i + CIW'(1);
                end else begin
                    r_j <= r_j + RIW'(1);
                end
            end
            S_FIN: begin
                if (full) begin
                    r_res_st <= ST_FULL;
                end else begin
                    r_res_st  <= ST_ACCEPTED;
                    r_res_acc <= 1'b1;
                    r_res_num <= r_cnt + PNW'(1);
                end
            end
            S_RES: if (!r_out_vld || o_out.ready) begin
                r_out_acc <= r_res_acc;
                r_out_num <= r_res_num;
                r_out_st  <= r_res_st;
            end
            default: ;
        endcase
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cnt) <= MAX_POINTS)
        else $error("point count beyond store depth");

    a_acc_num: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_acc) |-> (r_out_num != '0 && r_out_st == ST_ACCEPTED))
        else $error("accepted result without point number");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != S_IDLE))
        else $error("sequencer idle after transaction");

    a_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && !full) |=> (r_cnt == $past(r_cnt) + PNW'(1)))
        else $error("point count not advanced on store");
endmodule
`default_nettype wire
